### rtl/core/logit_irls_iteration_step_assert.svh
// assertion macros for the logit irls update block
// used by the top level; expects signals clk and rst in scope
`ifndef LOGIT_IRLS_ITERATION_STEP_ASSERT_SVH
`define LOGIT_IRLS_ITERATION_STEP_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define LIRS_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lirs assertion failed");
// next-cycle implication
`define LIRS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lirs assertion failed");
`else
`define LIRS_ASSERT(lbl, ante, cons)
`define LIRS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### rtl/core/lirs_pkg.sv
// shared constants, types and sequencer states of the logit irls update block
// no dependencies
package lirs_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int Q30           = 30;

  // shared divider geometry
  localparam int DIV_W      = 64;
  localparam int DIVR_W     = 32;
  localparam int DIV_STEP_W = 5;

  // shared multiplier geometry
  localparam int MUL_AW = 36;
  localparam int MUL_BW = 32;
  localparam int MUL_PW = MUL_AW + MUL_BW;

  localparam logic [29:0] LN2_Q30   = 30'd744261118;
  localparam logic [35:0] EXP_CLAMP = 36'd47244640256;
  localparam logic [30:0] ONE30     = 31'h4000_0000;
  localparam logic [30:0] MAX31     = 31'h7FFF_FFFF;

  localparam logic [4:0] TAYLOR_TERMS = 5'd14;
  localparam logic [4:0] LN_LAST_N    = 5'd21;

  // divider step counts (four quotient bits per step)
  localparam logic [DIV_STEP_W-1:0] STEPS_K   = 5'd9;
  localparam logic [DIV_STEP_W-1:0] STEPS_SML = 5'd8;
  localparam logic [DIV_STEP_W-1:0] STEPS_MU  = 5'd16;
  localparam logic [DIV_STEP_W-1:0] STEPS_LNS = 5'd15;

  typedef struct packed {
    logic                  start;
    logic [DIV_W-1:0]      dividend;
    logic [DIVR_W-1:0]     divisor;
    logic [DIV_STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_W-1:0]  quo;
    logic [DIVR_W-1:0] rem;
  } div_rsp_t;

  typedef enum logic [5:0] {
    ST_IDLE, ST_ETA, ST_ABS, ST_KDIV, ST_TMUL, ST_TDIV_GO, ST_TDIV_W, ST_EXPSH,
    ST_MU_GO, ST_MU_W, ST_WMUL, ST_WPROD, ST_Q_GO, ST_Q_W, ST_LHS, ST_WOUT,
    ST_LN_INIT, ST_LN_NORM, ST_LN_S_GO, ST_LN_S_W, ST_LN_SQ, ST_LN_S2,
    ST_LN_P_GO, ST_LN_P_W, ST_LN_PMUL, ST_LN_PUPD, ST_LN_K, ST_LN_FIN,
    ST_DEV1, ST_DEV2, ST_DEV3, ST_REL_GO, ST_REL_W, ST_DONE
  } state_t;

endpackage

### rtl/core/lirs_in_if.sv
// input channel of the logit irls update block: valid/ready plus one observation
// no dependencies
interface lirs_in_if;
  logic               valid;
  logic               ready;
  logic [16:0]        outcome;
  logic [30:0]        obs_weight;
  logic signed [31:0] fit_residual;
  logic signed [31:0] working_response_in;
  logic [30:0]        prev_deviance;
  logic               last_item;

  modport source (
    output valid, outcome, obs_weight, fit_residual, working_response_in,
           prev_deviance, last_item,
    input  ready
  );
  modport sink (
    input  valid, outcome, obs_weight, fit_residual, working_response_in,
           prev_deviance, last_item,
    output ready
  );
endinterface

### rtl/core/lirs_out_if.sv
// output channel of the logit irls update block: valid/ready plus one result
// no dependencies
interface lirs_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] linear_pred;
  logic [16:0]        probability;
  logic [30:0]        work_weight;
  logic signed [31:0] working_response_out;
  logic [30:0]        deviance;
  logic [30:0]        old_deviance;
  logic [30:0]        max_rel_change;
  logic               pass_done;

  modport source (
    output valid, linear_pred, probability, work_weight, working_response_out,
           deviance, old_deviance, max_rel_change, pass_done,
    input  ready
  );
  modport sink (
    input  valid, linear_pred, probability, work_weight, working_response_out,
           deviance, old_deviance, max_rel_change, pass_done,
    output ready
  );
endinterface

### rtl/core/lirs_mul.sv
// shared unsigned multiplier with a registered product
// depends on lirs_pkg
module lirs_mul (
  input  logic                        clk,
  input  logic [lirs_pkg::MUL_AW-1:0] a,
  input  logic [lirs_pkg::MUL_BW-1:0] b,
  output logic [lirs_pkg::MUL_PW-1:0] p
);

  // one product per cycle, available the cycle after the operands
  always_ff @(posedge clk) begin
    p <= {{lirs_pkg::MUL_BW{1'b0}}, a} * {{lirs_pkg::MUL_AW{1'b0}}, b};
  end

endmodule

### rtl/core/lirs_div.sv
// shared unsigned radix-16 restoring divider, quotient and remainder
// depends on lirs_pkg
module lirs_div (
  input  logic               clk,
  input  logic               rst,
  input  lirs_pkg::div_req_t req,
  output lirs_pkg::div_rsp_t rsp
);

  localparam int DW  = lirs_pkg::DIV_W;
  localparam int RW  = lirs_pkg::DIVR_W;
  localparam int SHW = $clog2(DW + 1);

  logic                            busy;
  logic                            done;
  logic [DW-1:0]                   num;
  logic [RW-1:0]                   rem;
  logic [RW-1:0]                   dvs;
  logic [lirs_pkg::DIV_STEP_W-1:0] cnt;
  logic [SHW-1:0]                  shamt;
  logic [DW-1:0]                   num_step;
  logic [RW-1:0]                   rem_step;
  logic [RW:0]                     trial;

  // align the dividend so only its low 4*steps bits are consumed
  assign shamt = SHW'(DW) - SHW'({req.steps, 2'b00});

  // four compare-subtract steps per cycle
  always_comb begin
    num_step = num;
    rem_step = rem;
    trial    = '0;
    for (int i = 0; i < 4; i++) begin
      trial    = {rem_step, num_step[DW-1]};
      num_step = {num_step[DW-2:0], 1'b0};
      if (trial >= {1'b0, dvs}) begin
        rem_step    = RW'(trial - {1'b0, dvs});
        num_step[0] = 1'b1;
      end else begin
        rem_step = trial[RW-1:0];
      end
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      num <= req.dividend << shamt;
      rem <= '0;
      dvs <= req.divisor;
      cnt <= req.steps;
    end else if (busy) begin
      num <= num_step;
      rem <= rem_step;
      cnt <= cnt - 1'b1;
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = num;
  assign rsp.rem  = rem;

endmodule

### rtl/core/logit_irls_iteration_step.sv
// One observation of a logistic regression IRLS pass per transaction, signed fixed
// point with FRAC_BITS fraction bits. A small sequencer drives one shared multiplier
// and one shared radix-16 divider through exp(-|eta|) (14 Taylor terms), the logistic
// mean, the working weight and response, two logarithms (atanh series to n = 21) and
// the relative deviance change; about 42 divisions dominate, and the correction
// division is skipped when the working weight is zero.
// The block takes one item at a time: ready is high only while idle, and a result
// holds until taken. use_weights must be written through cfg_wen/cfg_wdata only
// while idle; the user must ensure this, as the block itself does not enforce it.
module logit_irls_iteration_step #(
  parameter int FRAC_BITS = lirs_pkg::FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wen,
  input  logic       cfg_wdata,
  lirs_in_if.sink    in_ch,
  lirs_out_if.source out_ch
);

`include "logit_irls_iteration_step_assert.svh"

  localparam int          UP      = lirs_pkg::Q30 - FRAC_BITS;
  localparam logic [24:0] ONE_F   = 25'(1) << FRAC_BITS;
  localparam logic [4:0]  STEPS_Q = 5'((31 + FRAC_BITS + 3) / 4);
  localparam logic signed [56:0] Q_SAT = 57'sd1099511627776;

  lirs_pkg::state_t   state, state_next;
  lirs_pkg::div_req_t div_req;
  lirs_pkg::div_rsp_t div_rsp;
  logic [lirs_pkg::MUL_AW-1:0] mul_a;
  logic [lirs_pkg::MUL_BW-1:0] mul_b;
  logic [lirs_pkg::MUL_PW-1:0] prod;

  logic               use_weights;
  logic [16:0]        y_r;
  logic [30:0]        wobs;
  logic [30:0]        dev0;
  logic               last_r;
  logic signed [31:0] lin;
  logic signed [31:0] res;
  logic signed [31:0] eta;
  logic [6:0]         k_r;
  logic [29:0]        r_r;
  logic [30:0]        tmag;
  logic               tneg;
  logic signed [31:0] sum_r;
  logic [4:0]         cnt;
  logic [30:0]        z;
  logic [30:0]        mu30;
  logic [30:0]        om30;
  logic [30:0]        w30;
  logic signed [56:0] q;
  logic signed [31:0] lhs;
  logic [30:0]        wout;
  logic [16:0]        mu_f;
  logic [30:0]        lx;
  logic [4:0]         lk;
  logic [30:0]        s_r;
  logic [30:0]        s2;
  logic [30:0]        p_r;
  logic [32:0]        acc;
  logic               ln_sel;
  logic [35:0]        l1;
  logic [35:0]        l2;
  logic [61:0]        tsum;
  logic [30:0]        dev;
  logic [30:0]        run_max;

  logic signed [32:0] eta_diff;
  logic signed [31:0] eta_sat;
  logic [31:0]        abs_eta;
  logic [53:0]        a_full;
  logic [35:0]        a_cl;
  logic [30:0]        z_next;
  logic [31:0]        y30;
  logic signed [31:0] diff;
  logic [30:0]        abs_diff;
  logic signed [57:0] lhs_sum;
  logic signed [31:0] lhs_sat;
  logic [30:0]        mu_sh;
  logic [30:0]        ln_src;
  logic [35:0]        ln_val;
  logic [61:0]        tsum_tot;
  logic [30:0]        rel_num;
  logic [30:0]        rel;

  lirs_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(prod));
  lirs_div u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));

  // linear predictor and exp argument
  assign eta_diff = {lin[31], lin} - {res[31], res};
  assign eta_sat  = (eta_diff[32] != eta_diff[31]) ?
                    (eta_diff[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : eta_diff[31:0];
  assign abs_eta  = eta[31] ? 32'(-eta) : 32'(eta);
  assign a_full   = 54'(abs_eta) << UP;
  assign a_cl     = (a_full > 54'(lirs_pkg::EXP_CLAMP)) ? lirs_pkg::EXP_CLAMP
                                                         : a_full[35:0];
  assign z_next   = (k_r >= 7'd63) ? '0 : 31'(sum_r[30:0] >> k_r[5:0]);

  // working response terms
  assign y30      = 32'(y_r) << UP;
  assign diff     = $signed(y30) - $signed({1'b0, mu30});
  assign abs_diff = diff[31] ? 31'(-diff) : diff[30:0];
  assign lhs_sum  = {{26{eta[31]}}, eta} + {q[56], q};
  assign lhs_sat  = (lhs_sum > 58'sd2147483647) ? 32'sh7FFF_FFFF :
                    (lhs_sum < -58'sd2147483648) ? 32'sh8000_0000 : lhs_sum[31:0];
  assign mu_sh    = 31'(mu30 >> UP);

  // logarithm and deviance terms
  assign ln_src   = ln_sel ? om30 : mu30;
  assign ln_val   = prod[35:0] - {2'b00, acc, 1'b0};
  assign tsum_tot = tsum + prod[61:0];
  assign rel_num  = (dev >= dev0) ? (dev - dev0) : (dev0 - dev);
  assign rel      = (|div_rsp.quo[63:31]) ? lirs_pkg::MAX31 : div_rsp.quo[30:0];

  // handshake
  assign in_ch.ready  = (state == lirs_pkg::ST_IDLE);
  assign out_ch.valid = (state == lirs_pkg::ST_DONE);

  assign out_ch.linear_pred          = eta;
  assign out_ch.probability          = mu_f;
  assign out_ch.work_weight          = wout;
  assign out_ch.working_response_out = lhs;
  assign out_ch.deviance             = dev;
  assign out_ch.old_deviance         = dev0;
  assign out_ch.max_rel_change       = run_max;
  assign out_ch.pass_done            = last_r;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lirs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer: next state and shared unit operands
  always_comb begin
    state_next = state;
    mul_a      = '0;
    mul_b      = '0;
    div_req    = '0;
    case (state)
      lirs_pkg::ST_IDLE: begin
        if (in_ch.valid) state_next = lirs_pkg::ST_ETA;
      end
      lirs_pkg::ST_ETA: state_next = lirs_pkg::ST_ABS;
      lirs_pkg::ST_ABS: begin
        div_req.start    = 1'b1;
        div_req.dividend = 64'(a_cl);
        div_req.divisor  = 32'(lirs_pkg::LN2_Q30);
        div_req.steps    = lirs_pkg::STEPS_K;
        state_next       = lirs_pkg::ST_KDIV;
      end
      lirs_pkg::ST_KDIV: begin
        if (div_rsp.done) state_next = lirs_pkg::ST_TMUL;
      end
      lirs_pkg::ST_TMUL: begin
        mul_a      = 36'(tmag);
        mul_b      = 32'(r_r);
        state_next = lirs_pkg::ST_TDIV_GO;
      end
      lirs_pkg::ST_TDIV_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = 64'(prod[67:30]);
        div_req.divisor  = 32'(cnt);
        div_req.steps    = lirs_pkg::STEPS_SML;
        state_next       = lirs_pkg::ST_TDIV_W;
      end
      lirs_pkg::ST_TDIV_W: begin
        if (div_rsp.done) begin
          state_next = (cnt == lirs_pkg::TAYLOR_TERMS) ? lirs_pkg::ST_EXPSH
                                                       : lirs_pkg::ST_TMUL;
        end
      end
      lirs_pkg::ST_EXPSH: state_next = lirs_pkg::ST_MU_GO;
      lirs_pkg::ST_MU_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = eta[31] ? (64'(z) << 30) : (64'(1) << 60);
        div_req.divisor  = 32'(z) + 32'(lirs_pkg::ONE30);
        div_req.steps    = lirs_pkg::STEPS_MU;
        state_next       = lirs_pkg::ST_MU_W;
      end
      lirs_pkg::ST_MU_W: begin
        if (div_rsp.done) state_next = lirs_pkg::ST_WMUL;
      end
      lirs_pkg::ST_WMUL: begin
        mul_a      = 36'(mu30);
        mul_b      = 32'(om30);
        state_next = lirs_pkg::ST_WPROD;
      end
      lirs_pkg::ST_WPROD: state_next = lirs_pkg::ST_Q_GO;
      lirs_pkg::ST_Q_GO: begin
        if (w30 == '0) begin
          state_next = lirs_pkg::ST_LHS;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = 64'(abs_diff) << FRAC_BITS;
          div_req.divisor  = 32'(w30);
          div_req.steps    = STEPS_Q;
          state_next       = lirs_pkg::ST_Q_W;
        end
      end
      lirs_pkg::ST_Q_W: begin
        if (div_rsp.done) state_next = lirs_pkg::ST_LHS;
      end
      lirs_pkg::ST_LHS: begin
        mul_a      = 36'(w30);
        mul_b      = 32'(wobs);
        state_next = lirs_pkg::ST_WOUT;
      end
      lirs_pkg::ST_WOUT:    state_next = lirs_pkg::ST_LN_INIT;
      lirs_pkg::ST_LN_INIT: state_next = lirs_pkg::ST_LN_NORM;
      lirs_pkg::ST_LN_NORM: begin
        if (lx[30]) state_next = lirs_pkg::ST_LN_S_GO;
      end
      lirs_pkg::ST_LN_S_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = 64'(lx[29:0]) << 30;
        div_req.divisor  = 32'(lx) + 32'(lirs_pkg::ONE30);
        div_req.steps    = lirs_pkg::STEPS_LNS;
        state_next       = lirs_pkg::ST_LN_S_W;
      end
      lirs_pkg::ST_LN_S_W: begin
        if (div_rsp.done) state_next = lirs_pkg::ST_LN_SQ;
      end
      lirs_pkg::ST_LN_SQ: begin
        mul_a      = 36'(s_r);
        mul_b      = 32'(s_r);
        state_next = lirs_pkg::ST_LN_S2;
      end
      lirs_pkg::ST_LN_S2: state_next = lirs_pkg::ST_LN_P_GO;
      lirs_pkg::ST_LN_P_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = 64'(p_r);
        div_req.divisor  = 32'(cnt);
        div_req.steps    = lirs_pkg::STEPS_SML;
        state_next       = lirs_pkg::ST_LN_P_W;
      end
      lirs_pkg::ST_LN_P_W: begin
        if (div_rsp.done) begin
          state_next = (cnt == lirs_pkg::LN_LAST_N) ? lirs_pkg::ST_LN_K
                                                    : lirs_pkg::ST_LN_PMUL;
        end
      end
      lirs_pkg::ST_LN_PMUL: begin
        mul_a      = 36'(p_r);
        mul_b      = 32'(s2);
        state_next = lirs_pkg::ST_LN_PUPD;
      end
      lirs_pkg::ST_LN_PUPD: state_next = lirs_pkg::ST_LN_P_GO;
      lirs_pkg::ST_LN_K: begin
        mul_a      = 36'(lk);
        mul_b      = 32'(lirs_pkg::LN2_Q30);
        state_next = lirs_pkg::ST_LN_FIN;
      end
      lirs_pkg::ST_LN_FIN: begin
        state_next = ln_sel ? lirs_pkg::ST_DEV1 : lirs_pkg::ST_LN_INIT;
      end
      lirs_pkg::ST_DEV1: begin
        mul_a      = l1;
        mul_b      = 32'(y_r);
        state_next = lirs_pkg::ST_DEV2;
      end
      lirs_pkg::ST_DEV2: begin
        mul_a      = l2;
        mul_b      = 32'(ONE_F - 25'(y_r));
        state_next = lirs_pkg::ST_DEV3;
      end
      lirs_pkg::ST_DEV3: state_next = lirs_pkg::ST_REL_GO;
      lirs_pkg::ST_REL_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = 64'(rel_num) << FRAC_BITS;
        div_req.divisor  = 32'(dev0) + 32'(ONE_F);
        div_req.steps    = STEPS_Q;
        state_next       = lirs_pkg::ST_REL_W;
      end
      lirs_pkg::ST_REL_W: begin
        if (div_rsp.done) state_next = lirs_pkg::ST_DONE;
      end
      lirs_pkg::ST_DONE: begin
        if (out_ch.ready) state_next = lirs_pkg::ST_IDLE;
      end
      default: state_next = lirs_pkg::ST_IDLE;
    endcase
  end

  // configuration and pass-wide running maximum
  always_ff @(posedge clk) begin
    if (rst) begin
      use_weights <= 1'b0;
      run_max     <= '0;
    end else begin
      if (cfg_wen) use_weights <= cfg_wdata;
      if (state == lirs_pkg::ST_REL_W && div_rsp.done && rel > run_max) begin
        run_max <= rel;
      end
      if (state == lirs_pkg::ST_DONE && out_ch.ready && last_r) begin
        run_max <= '0;
      end
    end
  end

  // datapath registers, loaded step by step
  always_ff @(posedge clk) begin
    case (state)
      lirs_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          y_r    <= (25'(in_ch.outcome) > ONE_F) ? 17'(ONE_F) : in_ch.outcome;
          wobs   <= in_ch.obs_weight;
          dev0   <= in_ch.prev_deviance;
          last_r <= in_ch.last_item;
          lin    <= in_ch.working_response_in;
          res    <= in_ch.fit_residual;
        end
      end
      lirs_pkg::ST_ETA: eta <= eta_sat;
      lirs_pkg::ST_KDIV: begin
        if (div_rsp.done) begin
          k_r   <= div_rsp.quo[6:0];
          r_r   <= div_rsp.rem[29:0];
          tmag  <= lirs_pkg::ONE30;
          tneg  <= 1'b0;
          sum_r <= 32'(lirs_pkg::ONE30);
          cnt   <= 5'd1;
        end
      end
      lirs_pkg::ST_TDIV_W: begin
        // terms alternate in sign, each truncated toward zero
        if (div_rsp.done) begin
          tmag  <= div_rsp.quo[30:0];
          tneg  <= ~tneg;
          sum_r <= tneg ? sum_r + 32'(div_rsp.quo[30:0])
                        : sum_r - 32'(div_rsp.quo[30:0]);
          cnt   <= cnt + 5'd1;
        end
      end
      lirs_pkg::ST_EXPSH: z <= z_next;
      lirs_pkg::ST_MU_W: begin
        if (div_rsp.done) begin
          mu30 <= div_rsp.quo[30:0];
          om30 <= lirs_pkg::ONE30 - div_rsp.quo[30:0];
        end
      end
      lirs_pkg::ST_WPROD: w30 <= prod[60:30];
      lirs_pkg::ST_Q_GO: begin
        // zero weight: saturate the correction with the sign of y - mu
        if (w30 == '0) begin
          q <= diff[31] ? -Q_SAT : ((diff == '0) ? '0 : Q_SAT);
        end
      end
      lirs_pkg::ST_Q_W: begin
        if (div_rsp.done) begin
          q <= diff[31] ? -$signed({1'b0, div_rsp.quo[55:0]})
                        : $signed({1'b0, div_rsp.quo[55:0]});
        end
      end
      lirs_pkg::ST_LHS: lhs <= lhs_sat;
      lirs_pkg::ST_WOUT: begin
        if (use_weights) begin
          wout <= (|prod[67:61]) ? lirs_pkg::MAX31 : prod[60:30];
        end else begin
          wout <= 31'(w30 >> UP);
        end
        mu_f   <= (mu_sh > 31'h1FFFF) ? 17'h1FFFF : mu_sh[16:0];
        ln_sel <= 1'b0;
      end
      lirs_pkg::ST_LN_INIT: begin
        lx <= (ln_src == '0) ? 31'd1 : ln_src;
        lk <= '0;
      end
      lirs_pkg::ST_LN_NORM: begin
        if (!lx[30]) begin
          lx <= {lx[29:0], 1'b0};
          lk <= lk + 5'd1;
        end
      end
      lirs_pkg::ST_LN_S_W: begin
        if (div_rsp.done) begin
          s_r <= div_rsp.quo[30:0];
          p_r <= div_rsp.quo[30:0];
          acc <= '0;
          cnt <= 5'd1;
        end
      end
      lirs_pkg::ST_LN_S2: s2 <= prod[60:30];
      lirs_pkg::ST_LN_P_W: begin
        if (div_rsp.done) acc <= acc + 33'(div_rsp.quo[30:0]);
      end
      lirs_pkg::ST_LN_PUPD: begin
        p_r <= prod[60:30];
        cnt <= cnt + 5'd2;
      end
      lirs_pkg::ST_LN_FIN: begin
        // magnitude of the (non-positive) logarithm
        if (ln_sel) begin
          l2 <= ln_val;
        end else begin
          l1 <= ln_val;
        end
        ln_sel <= 1'b1;
      end
      lirs_pkg::ST_DEV2: tsum <= prod[61:0];
      lirs_pkg::ST_DEV3: begin
        dev <= (|tsum_tot[61:60]) ? lirs_pkg::MAX31 : tsum_tot[59:29];
      end
      default: begin
      end
    endcase
  end

  // checks
  `LIRS_ASSERT(a_ready_not_while_result, in_ch.ready, !out_ch.valid)
  `LIRS_ASSERT_NEXT(a_max_cleared_after_pass, out_ch.valid && out_ch.ready && out_ch.pass_done, out_ch.max_rel_change == '0)
  `LIRS_ASSERT(a_probability_in_range, out_ch.valid, 25'(out_ch.probability) <= ONE_F)

endmodule

### dv/tb_top.sv
// testbench for the logit irls update block: directed and random observations,
// both weight settings, random and long stalls on both channels
// depends on lirs_in_if, lirs_out_if and logit_irls_iteration_step
module tb_top;

  localparam int    FB      = 16;
  localparam longint ONE_Q30 = 64'sd1 << 30;
  localparam longint LN2     = 64'sd744261118;
  localparam longint SAT31   = 64'sd2147483647;

  typedef struct {
    logic signed [31:0] linear_pred;
    logic [16:0]        probability;
    logic [30:0]        work_weight;
    logic signed [31:0] working_response_out;
    logic [30:0]        deviance;
    logic [30:0]        old_deviance;
    logic [30:0]        max_rel_change;
    logic               pass_done;
  } update_t;

  logic clk;
  logic rst;
  logic cfg_wen;
  logic cfg_wdata;

  lirs_in_if  in_ch ();
  lirs_out_if out_ch ();

  logit_irls_iteration_step dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // predictor state
  bit      weights_on;
  longint  pass_max;
  update_t pending_updates[$];
  int      errors;
  int      hold_off;
  bit      sender_gap_on;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #200000000;
    $display("tb_top failed");
    $finish;
  end

  function automatic longint sat_s32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint sat_u31(longint v);
    if (v < 0) return 0;
    return (v > SAT31) ? SAT31 : v;
  endfunction

  // exp(-a) in Q30 by range reduction and a truncated Taylor series
  function automatic longint exp_neg_q30(longint a);
    longint k, r, term, sum;
    term = ONE_Q30;
    sum  = ONE_Q30;
    if (a > (64'sd44 << 30)) a = 64'sd44 << 30;
    k = a / LN2;
    r = a - k * LN2;
    for (int n = 1; n <= 14; n++) begin
      term = -((term * r) / (n * ONE_Q30));
      sum += term;
    end
    if (k >= 63) return 0;
    return longint'(longint'(unsigned'(sum)) >>> 0) >> k;
  endfunction

  // natural log in Q30 of a value in (0, 1], via atanh series
  function automatic longint ln_q30(longint x);
    longint k, s, s2, p, acc;
    k = 0;
    acc = 0;
    if (x < 1) x = 1;
    if (x > ONE_Q30) x = ONE_Q30;
    while (x < ONE_Q30) begin
      x = x * 2;
      k++;
    end
    s  = ((x - ONE_Q30) * ONE_Q30) / (x + ONE_Q30);
    s2 = (s * s) / ONE_Q30;
    p  = s;
    for (int n = 1; n <= 21; n += 2) begin
      acc += p / n;
      p = (p * s2) / ONE_Q30;
    end
    return 2 * acc - k * LN2;
  endfunction

  // expected update for one observation; advances the pass maximum
  function automatic update_t irls_update(logic [16:0] y_in, logic [30:0] w_in,
                                          logic signed [31:0] res,
                                          logic signed [31:0] z_in,
                                          logic [30:0] dev_in, logic last);
    update_t u;
    longint one_f, y, wobs, dev0, eta, z, mu, om, w30, diff, q, wout;
    longint l1, l2, t, dev, num, rel, mu_f;
    int up;
    up    = 30 - FB;
    one_f = 64'sd1 << FB;
    y     = longint'(y_in);
    wobs  = longint'(w_in);
    dev0  = longint'(dev_in);
    if (y > one_f) y = one_f;
    eta = sat_s32(longint'(z_in) - longint'(res));
    z = exp_neg_q30((eta < 0 ? -eta : eta) << up);
    if (eta >= 0) mu = (64'sd1 << 60) / (ONE_Q30 + z);
    else mu = (z * ONE_Q30) / (ONE_Q30 + z);
    om  = ONE_Q30 - mu;
    w30 = (mu * om) / ONE_Q30;
    diff = y * (64'sd1 << up) - mu;
    if (w30 == 0) q = (diff > 0) ? (64'sd1 << 40) : ((diff < 0) ? -(64'sd1 << 40) : 0);
    else q = (diff * one_f) / w30;
    if (weights_on) wout = sat_u31((w30 * wobs) / ONE_Q30);
    else wout = sat_u31(w30 / (64'sd1 << up));
    l1 = ln_q30(mu);
    l2 = ln_q30(om);
    t = y * l1 + (one_f - y) * l2;
    dev = (t >= 0) ? 0 : sat_u31((2 * (-t)) / ONE_Q30);
    num = (dev >= dev0) ? dev - dev0 : dev0 - dev;
    rel = sat_u31((num * one_f) / (dev0 + one_f));
    if (rel > pass_max) pass_max = rel;
    mu_f = mu / (64'sd1 << up);
    if (mu_f > 64'h1FFFF) mu_f = 64'h1FFFF;
    u.linear_pred          = eta[31:0];
    u.probability          = mu_f[16:0];
    u.work_weight          = wout[30:0];
    u.working_response_out = sat_s32(eta + q);
    u.deviance             = dev[30:0];
    u.old_deviance         = dev_in;
    u.max_rel_change       = pass_max[30:0];
    u.pass_done            = last;
    if (last) pass_max = 0;
    return u;
  endfunction

  // send one observation; valid stays high into the next call when it has no gap
  task automatic send_obs(logic [16:0] y, logic [30:0] w, logic signed [31:0] res,
                          logic signed [31:0] z, logic [30:0] dev0, logic last);
    int gap;
    gap = sender_gap_on ? $urandom_range(0, 12) : 0;
    if (gap > 0 && in_ch.valid) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid               <= 1'b1;
    in_ch.outcome             <= y;
    in_ch.obs_weight          <= w;
    in_ch.fit_residual        <= res;
    in_ch.working_response_in <= z;
    in_ch.prev_deviance       <= dev0;
    in_ch.last_item           <= last;
    do @(posedge clk); while (!in_ch.ready);
    pending_updates.push_back(irls_update(y, w, res, z, dev0, last));
  endtask

  task automatic idle_sender();
    if (in_ch.valid) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    idle_sender();
    while (pending_updates.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_use_weights(bit v);
    wait_drained();
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen <= 1'b0;
    weights_on = v;
    @(posedge clk);
  endtask

  // random observation: mostly moderate eta, some over the full range
  task automatic send_random(logic last);
    logic signed [31:0] res, z;
    longint eta;
    int pick;
    pick = $urandom_range(0, 9);
    res = $urandom;
    if (pick < 7) begin
      eta = $signed($urandom_range(0, 24 * 65536)) - 12 * 65536;
      if (longint'(res) + eta > 64'sd2147483647 || longint'(res) + eta < -64'sd2147483648)
        res = 0;
      z = 32'(longint'(res) + eta);
    end else begin
      z = $urandom;
    end
    send_obs((pick == 9) ? 17'($urandom) : 17'($urandom_range(0, 65536)),
             31'($urandom), res, z,
             ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(0, 1 << 20)),
             last);
  endtask

  task automatic random_pass(int n);
    for (int i = 0; i < n; i++) send_random(i == n - 1 || $urandom_range(0, 15) == 0);
  endtask

  // extremes of every field and the saturating corners
  task automatic test_directed();
    send_obs(17'd0, 31'd0, 32'sd0, 32'sd0, 31'd0, 1'b0);
    send_obs(17'd32768, 31'd65536, 32'sd0, 32'sd0, 31'd0, 1'b0);
    send_obs(17'd65536, 31'h7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 1'b0);
    send_obs(17'd0, 31'h7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 31'd0, 1'b1);
    send_obs(17'h1FFFF, 31'd1, 32'sd0, 32'sd0, 31'd100, 1'b0);
    send_obs(17'd65536, 31'd65536, 32'sd0, 32'sd3000000, 31'd5, 1'b0);
    send_obs(17'd0, 31'd65536, 32'sd0, 32'sd3000000, 31'd5, 1'b0);
    send_obs(17'd65536, 31'd65536, 32'sd3000000, 32'sd0, 31'd5, 1'b0);
    send_obs(17'd0, 31'd65536, 32'sd3000000, 32'sd0, 31'd5, 1'b1);
    send_obs(17'd65536, 31'd1, 32'sd65536, 32'sd0, 31'h7FFF_FFFF, 1'b0);
    send_obs(17'd1, 31'h4000_0000, -32'sd65536, 32'sd0, 31'd1, 1'b0);
    send_obs(17'd40000, 31'h1234_5678, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 31'd0, 1'b1);
  endtask

  task automatic test_weights_off();
    write_use_weights(1'b0);
    for (int i = 0; i < 10; i++) random_pass(60);
  endtask

  task automatic test_weights_on();
    write_use_weights(1'b1);
    test_directed();
    for (int i = 0; i < 10; i++) random_pass(60);
  endtask

  // receiver holds off for a long stretch while the sender keeps offering
  task automatic test_backpressure();
    hold_off = 3000;
    random_pass(20);
  endtask

  // sender stops until everything is back, then resumes back-to-back
  task automatic test_pause_and_burst();
    wait_drained();
    sender_gap_on = 0;
    random_pass(80);
    sender_gap_on = 1;
  endtask

  // result side: random stalls, each transaction checked against the oldest prediction
  initial begin
    int stall;
    update_t e;
    out_ch.ready = 1'b0;
    @(negedge rst);
    forever begin
      stall = (hold_off > 0) ? hold_off : $urandom_range(0, 12);
      if ($urandom_range(0, 5) == 0 && hold_off == 0) stall = 0;
      hold_off = 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      if (pending_updates.size() == 0) begin
        $display("%0t unexpected result transaction", $time);
        errors++;
      end else begin
        e = pending_updates.pop_front();
        if (out_ch.linear_pred !== e.linear_pred ||
            out_ch.probability !== e.probability ||
            out_ch.work_weight !== e.work_weight ||
            out_ch.working_response_out !== e.working_response_out ||
            out_ch.deviance !== e.deviance ||
            out_ch.old_deviance !== e.old_deviance ||
            out_ch.max_rel_change !== e.max_rel_change ||
            out_ch.pass_done !== e.pass_done) begin
          $display("%0t mismatch exp eta=%0d mu=%0d w=%0d z=%0d dev=%0d dev0=%0d max=%0d done=%0b",
                   $time, e.linear_pred, e.probability, e.work_weight,
                   e.working_response_out, e.deviance, e.old_deviance,
                   e.max_rel_change, e.pass_done);
          $display("%0t          act eta=%0d mu=%0d w=%0d z=%0d dev=%0d dev0=%0d max=%0d done=%0b",
                   $time, out_ch.linear_pred, out_ch.probability, out_ch.work_weight,
                   out_ch.working_response_out, out_ch.deviance, out_ch.old_deviance,
                   out_ch.max_rel_change, out_ch.pass_done);
          errors++;
        end
      end
    end
  end

  // sequence of tests
  initial begin
    rst = 1'b1;
    cfg_wen = 1'b0;
    cfg_wdata = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.outcome = '0;
    in_ch.obs_weight = '0;
    in_ch.fit_residual = '0;
    in_ch.working_response_in = '0;
    in_ch.prev_deviance = '0;
    in_ch.last_item = 1'b0;
    weights_on = 0;
    pass_max = 0;
    errors = 0;
    hold_off = 0;
    sender_gap_on = 1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_weights_off();
    test_backpressure();
    test_weights_on();
    test_pause_and_burst();
    write_use_weights(1'b0);
    random_pass(40);
    wait_drained();
    repeat (700) @(posedge clk);
    if (errors == 0 && pending_updates.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end
endmodule
